/* rtl/core/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the chunk stream counter.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Width of the internal chunk counters; results show the low 16 bits.
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned HDR_BYTES    = 6;
  localparam int unsigned OUT_TDATA_W  = 40;

  localparam logic [15:0] ID_MAIN     = 16'h4D4D;
  localparam logic [15:0] ID_EDITOR   = 16'h3D3D;
  localparam logic [15:0] ID_MATERIAL = 16'hAFFF;
  localparam logic [15:0] ID_OBJECT   = 16'h4000;
  localparam logic [15:0] ID_MESH     = 16'h4100;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_BODY   = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_IN_HEADER = 2'd1,
    ST_IN_BODY   = 2'd2,
    ST_MALFORMED = 2'd3
  } end_status_t;

  // One result beat, last member in the lowest bits.
  typedef struct packed {
    end_status_t end_status;
    logic [15:0] mesh_count;
    logic [15:0] material_count;
  } result_t;

endpackage

/* rtl/core/chunk_stream_counter_unit.sv */
// ----------------------------------------------------------------------------
// chunk_stream_counter_unit
// Byte-serial walker for a chunked model file that counts material and
// mesh chunks and reports the counts and an end status on the last byte.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat content
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | one file byte; tlast marks the final byte of the file
//  out_    | master    | counts and end status, one beat per file
//
// Every byte beat is absorbed in the cycle it is accepted, so the input side
// takes one beat per clock. A result is registered in the output register or,
// while that register stays full, in the skid. Two result slots (output
// register plus skid) keep in_tready high while a single result waits;
// in_tready drops only when both slots hold results. rst_n is synchronous
// and active low; it clears the walker state and empties both result slots.
//
module chunk_stream_counter_unit
  import csc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] material_count, [31:16] mesh_count, [33:32] end_status, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Walker state.
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hdr_idx_r, hdr_idx_nxt;
  logic [39:0]            hdr_shift_r, hdr_shift_nxt;   // first five header bytes
  logic [31:0]            skip_r, skip_nxt;
  logic [COUNT_WIDTH-1:0] mat_cnt_r, mat_cnt_nxt;
  logic [COUNT_WIDTH-1:0] mesh_cnt_r, mesh_cnt_nxt;

  // Result slots.
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;

  logic        beat_acc;
  logic        res_acc;
  logic        out_take;
  logic [15:0] hdr_id;
  logic [31:0] hdr_len;
  logic [31:0] len_rem;
  logic        len_short;
  logic [31:0] mat_ext;
  logic [31:0] mesh_ext;
  end_status_t status;
  result_t     res_data;

  assign in_tready = !skid_valid_r;
  assign beat_acc  = in_tvalid && in_tready;
  assign res_acc   = beat_acc && in_tlast;
  assign out_take  = out_valid_r && out_tready;

  // The sixth header byte is used straight from the input.
  assign hdr_id    = hdr_shift_r[15:0];
  assign hdr_len   = {in_tdata, hdr_shift_r[39:16]};
  assign len_short = hdr_len < 32'(HDR_BYTES);
  assign len_rem   = hdr_len - 32'(HDR_BYTES);

  // Walker next state for one accepted byte.
  always_comb begin
    phase_nxt     = phase_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_shift_nxt = hdr_shift_r;
    skip_nxt      = skip_r;
    mat_cnt_nxt   = mat_cnt_r;
    mesh_cnt_nxt  = mesh_cnt_r;

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_idx_r == 3'(HDR_BYTES - 1)) begin
          hdr_idx_nxt   = '0;
          hdr_shift_nxt = '0;
          priority if (hdr_id == ID_MAIN || hdr_id == ID_EDITOR) begin
            phase_nxt = PH_HEADER;
          end else if (hdr_id == ID_OBJECT) begin
            phase_nxt = PH_NAME;
          end else begin
            if (hdr_id == ID_MATERIAL) begin
              mat_cnt_nxt = mat_cnt_r + 1'b1;
            end
            if (hdr_id == ID_MESH) begin
              mesh_cnt_nxt = mesh_cnt_r + 1'b1;
            end
            // A length below the header size can never be walked past.
            if (len_short) begin
              phase_nxt = PH_BAD;
            end else begin
              skip_nxt  = len_rem;
              phase_nxt = (len_rem != '0) ? PH_BODY : PH_HEADER;
            end
          end
        end else begin
          hdr_shift_nxt[8*hdr_idx_r +: 8] = in_tdata;
          hdr_idx_nxt                     = hdr_idx_r + 3'd1;
        end
      end
      PH_NAME: begin
        if (in_tdata == 8'h00) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_BODY: begin
        // The body phase is only entered with a nonzero count.
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_BAD: begin
        phase_nxt = PH_BAD;
      end
      default: begin
        phase_nxt = PH_BAD;
      end
    endcase
  end

  // End status taken from the state after the last byte.
  always_comb begin
    unique case (phase_nxt)
      PH_HEADER: status = (hdr_idx_nxt == '0) ? ST_CLEAN : ST_IN_HEADER;
      PH_NAME:   status = ST_IN_BODY;
      PH_BODY:   status = ST_IN_BODY;
      PH_BAD:    status = ST_MALFORMED;
      default:   status = ST_MALFORMED;
    endcase
  end

  assign mat_ext  = 32'(mat_cnt_nxt);
  assign mesh_ext = 32'(mesh_cnt_nxt);

  always_comb begin
    res_data.end_status     = status;
    res_data.mesh_count     = mesh_ext[15:0];
    res_data.material_count = mat_ext[15:0];
  end

  // Result slots: a new result goes to the output register when it is free
  // (or being emptied), else into the skid register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (res_acc) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= '0;
      hdr_shift_r  <= '0;
      skip_r       <= '0;
      mat_cnt_r    <= '0;
      mesh_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (res_acc) begin
        // The walker starts over for the next file.
        phase_r     <= PH_HEADER;
        hdr_idx_r   <= '0;
        hdr_shift_r <= '0;
        skip_r      <= '0;
        mat_cnt_r   <= '0;
        mesh_cnt_r  <= '0;
      end else if (beat_acc) begin
        phase_r     <= phase_nxt;
        hdr_idx_r   <= hdr_idx_nxt;
        hdr_shift_r <= hdr_shift_nxt;
        skip_r      <= skip_nxt;
        mat_cnt_r   <= mat_cnt_nxt;
        mesh_cnt_r  <= mesh_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

/* rtl/core/csc_checker.sv */
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the chunk stream counter, bound to chunk_stream_counter_unit.
// ----------------------------------------------------------------------------
module csc_checker
  import csc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [7:0]             in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A held result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // After every accepted last byte, the output side holds a valid result in the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last byte");

  // The input side only stalls behind a result that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready dropped without a stalled result");

endmodule

bind chunk_stream_counter_unit csc_checker u_csc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
